// ===== sv/phsv2rgb_pkg.sv =====
package phsv2rgb_pkg;

    // Bit positions of the packed input word.
    localparam int unsigned HSV_FLAG_BIT = 31;
    localparam int unsigned HUE_NEG_BIT  = 30;

    localparam int unsigned HUE_RANGE = 360;
    localparam int unsigned HUE_SECT  = 60;
    localparam int unsigned REM_MAX   = 59;
    localparam int unsigned LEVEL_MAX = 63;
    localparam int unsigned QDIV      = LEVEL_MAX * REM_MAX;

    // Reciprocals for exact truncating division over the operand ranges in use.
    // A reciprocal k = ceil(2^n / d) is exact while x * (k * d - 2^n) < 2^n.
    localparam int unsigned       HUE_SHIFT = 20;
    localparam longint unsigned   HUE_RECIP =
        ((64'd1 << HUE_SHIFT) + HUE_RANGE - 1) / HUE_RANGE;
    localparam int unsigned       P_SHIFT   = 20;
    localparam longint unsigned   P_RECIP   =
        ((64'd1 << P_SHIFT) + LEVEL_MAX - 1) / LEVEL_MAX;
    localparam int unsigned       Q_SHIFT   = 32;
    localparam longint unsigned   Q_RECIP   =
        ((64'd1 << Q_SHIFT) + QDIV - 1) / QDIV;

    // Clock edges from an accepted request to its result strobe.
    localparam int unsigned LATENCY = 7;

    typedef enum logic [2:0] {
        REGION_0 = 3'd0,
        REGION_1 = 3'd1,
        REGION_2 = 3'd2,
        REGION_3 = 3'd3,
        REGION_4 = 3'd4,
        REGION_5 = 3'd5
    } region_t;

    typedef struct packed {
        region_t    region;
        logic [5:0] rem;
    } hue_t;

endpackage

// ===== sv/phsv2rgb_hue.sv =====
module phsv2rgb_hue (
    input  logic                clk,
    input  logic [11:0]         mag,
    input  logic                neg,
    output phsv2rgb_pkg::hue_t  hue
);

    logic [23:0] prod_next;
    logic [3:0]  quo_reg;
    logic [11:0] mag_reg;
    logic        neg1_reg;

    logic [11:0] red_next;
    logic [8:0]  h_next;
    logic [8:0]  h_reg;

    phsv2rgb_pkg::region_t region_next;
    logic [8:0]            base_next;
    phsv2rgb_pkg::hue_t    hue_reg;

    // Stage 1: quotient of the magnitude by the hue range.
    assign prod_next = mag * 12'(phsv2rgb_pkg::HUE_RECIP);

    // Stage 2: remainder, mirrored for a negative hue.
    always_comb
    begin
        red_next = mag_reg - (12'(quo_reg) * 12'(phsv2rgb_pkg::HUE_RANGE));
        if (neg1_reg && (red_next != 12'd0))
        begin
            h_next = 9'(phsv2rgb_pkg::HUE_RANGE) - red_next[8:0];
        end
        else
        begin
            h_next = red_next[8:0];
        end
    end

    // Stage 3: sector and offset inside the sector.
    always_comb
    begin
        if (h_reg >= 9'(5 * phsv2rgb_pkg::HUE_SECT))
        begin
            region_next = phsv2rgb_pkg::REGION_5;
            base_next   = 9'(5 * phsv2rgb_pkg::HUE_SECT);
        end
        else if (h_reg >= 9'(4 * phsv2rgb_pkg::HUE_SECT))
        begin
            region_next = phsv2rgb_pkg::REGION_4;
            base_next   = 9'(4 * phsv2rgb_pkg::HUE_SECT);
        end
        else if (h_reg >= 9'(3 * phsv2rgb_pkg::HUE_SECT))
        begin
            region_next = phsv2rgb_pkg::REGION_3;
            base_next   = 9'(3 * phsv2rgb_pkg::HUE_SECT);
        end
        else if (h_reg >= 9'(2 * phsv2rgb_pkg::HUE_SECT))
        begin
            region_next = phsv2rgb_pkg::REGION_2;
            base_next   = 9'(2 * phsv2rgb_pkg::HUE_SECT);
        end
        else if (h_reg >= 9'(phsv2rgb_pkg::HUE_SECT))
        begin
            region_next = phsv2rgb_pkg::REGION_1;
            base_next   = 9'(phsv2rgb_pkg::HUE_SECT);
        end
        else
        begin
            region_next = phsv2rgb_pkg::REGION_0;
            base_next   = 9'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg        <= prod_next[23:20];
        mag_reg        <= mag;
        neg1_reg       <= neg;
        h_reg          <= h_next;
        hue_reg.region <= region_next;
        hue_reg.rem    <= 6'(h_reg - base_next);
    end

    assign hue = hue_reg;

endmodule

// ===== sv/packed_hsv_to_rgb_convert.sv =====
// Channel   | Direction | Handshake      | Payload
// ----------+-----------+----------------+------------------------------------
// request   | in        | start, busy    | color_word[31:0]
// result    | out       | done           | rgb888_word[29:0], rgb565_word[15:0]
//
// A request is taken on any cycle with start high; busy is never raised.
// Each result is strobed by done for one cycle.
// The pipeline has seven stages: hue reduction, scaling,
// two multiply stages and reciprocal division, then channel selection.
// Reset clears the valid bits of every stage; payload registers are not reset.
// The receiver cannot stall the pipeline, so nothing is ever held back.
module packed_hsv_to_rgb_convert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] color_word,
    output logic        done,
    output logic [29:0] rgb888_word,
    output logic [15:0] rgb565_word
);

    logic [6:1]  valid_reg;
    logic [29:0] word_reg [1:6];
    logic        hsv_reg  [1:6];

    // Value through stage 6, saturation through stage 3.
    logic [7:0]  v_next;
    logic [7:0]  v_reg    [1:6];
    logic [5:0]  s_reg    [1:3];

    phsv2rgb_pkg::hue_t    hue;
    phsv2rgb_pkg::region_t region_reg [4:6];

    // Stage 4 products.
    logic [11:0] sr_dn_reg;
    logic [11:0] sr_up_reg;
    logic [13:0] pn_reg;

    // Stage 5 products.
    logic [19:0] nd_reg;
    logic [19:0] nu_reg;
    logic [28:0] pp_reg;

    // Stage 6 quotients.
    logic [40:0] qd_prod;
    logic [40:0] qu_prod;
    logic [7:0]  qdn_reg;
    logic [7:0]  qup_reg;
    logic [7:0]  p_reg;

    logic [7:0]  r_next;
    logic [7:0]  g_next;
    logic [7:0]  b_next;
    logic [29:0] c888_next;

    logic        done_reg;
    logic [29:0] rgb888_reg;
    logic [15:0] rgb565_reg;

    assign busy = 1'b0;

    phsv2rgb_hue u_hue (
        .clk (clk),
        .mag (color_word[23:12]),
        .neg (color_word[phsv2rgb_pkg::HUE_NEG_BIT]),
        .hue (hue)
    );

    // 255/63 = 4 + 3/63, so the scaled value is 4*v6 plus v6 divided by 21.
    always_comb
    begin
        v_next = {color_word[5:0], 2'b00};
        if (color_word[5:0] == 6'd63)
        begin
            v_next = v_next + 8'd3;
        end
        else if (color_word[5:0] >= 6'd42)
        begin
            v_next = v_next + 8'd2;
        end
        else if (color_word[5:0] >= 6'd21)
        begin
            v_next = v_next + 8'd1;
        end
    end

    assign qd_prod = nd_reg * 21'(phsv2rgb_pkg::Q_RECIP);
    assign qu_prod = nu_reg * 21'(phsv2rgb_pkg::Q_RECIP);

    always_comb
    begin
        case (region_reg[6])
            phsv2rgb_pkg::REGION_0:
            begin
                r_next = v_reg[6]; g_next = qup_reg;  b_next = p_reg;
            end
            phsv2rgb_pkg::REGION_1:
            begin
                r_next = qdn_reg;  g_next = v_reg[6]; b_next = p_reg;
            end
            phsv2rgb_pkg::REGION_2:
            begin
                r_next = p_reg;    g_next = v_reg[6]; b_next = qup_reg;
            end
            phsv2rgb_pkg::REGION_3:
            begin
                r_next = p_reg;    g_next = qdn_reg;  b_next = v_reg[6];
            end
            phsv2rgb_pkg::REGION_4:
            begin
                r_next = qup_reg;  g_next = p_reg;    b_next = v_reg[6];
            end
            default:
            begin
                r_next = v_reg[6]; g_next = p_reg;    b_next = qdn_reg;
            end
        endcase

        if (hsv_reg[6])
        begin
            c888_next = {word_reg[6][29:24], r_next, g_next, b_next};
        end
        else
        begin
            c888_next = word_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[5:1], start & ~busy};
            done_reg  <= valid_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg[1] <= color_word[29:0];
        hsv_reg[1]  <= color_word[phsv2rgb_pkg::HSV_FLAG_BIT];
        for (int i = 2; i <= 6; i++)
        begin
            word_reg[i] <= word_reg[i-1];
            hsv_reg[i]  <= hsv_reg[i-1];
        end

        v_reg[1] <= v_next;
        s_reg[1] <= color_word[11:6];
        for (int i = 2; i <= 6; i++)
        begin
            v_reg[i] <= v_reg[i-1];
        end
        for (int i = 2; i <= 3; i++)
        begin
            s_reg[i] <= s_reg[i-1];
        end

        // Stage 4: saturation products.
        region_reg[4] <= hue.region;
        sr_dn_reg     <= s_reg[3] * hue.rem;
        sr_up_reg     <= s_reg[3] * 6'(6'(phsv2rgb_pkg::REM_MAX) - hue.rem);
        pn_reg        <= v_reg[3] * 6'(6'(phsv2rgb_pkg::LEVEL_MAX) - s_reg[3]);

        // Stage 5: numerators and the reciprocal product for p.
        region_reg[5] <= region_reg[4];
        nd_reg        <= v_reg[4] * 12'(12'(phsv2rgb_pkg::QDIV) - sr_dn_reg);
        nu_reg        <= v_reg[4] * 12'(12'(phsv2rgb_pkg::QDIV) - sr_up_reg);
        pp_reg        <= pn_reg * 15'(phsv2rgb_pkg::P_RECIP);

        // Stage 6: quotients, all below 256.
        region_reg[6] <= region_reg[5];
        qdn_reg       <= qd_prod[39:32];
        qup_reg       <= qu_prod[39:32];
        p_reg         <= pp_reg[27:20];

        // Stage 7: output register.
        rgb888_reg <= c888_next;
        rgb565_reg <= {c888_next[23:19], c888_next[15:10], c888_next[7:3]};
    end

    assign done        = done_reg;
    assign rgb888_word = rgb888_reg;
    assign rgb565_word = rgb565_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, phsv2rgb_pkg::LATENCY))
        else $error("result strobe without a matching request");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##7 done)
        else $error("request lost in the pipeline");

    a_rgb_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        done && !$past(color_word[31], phsv2rgb_pkg::LATENCY)
        |-> rgb888_word == $past(color_word[29:0], phsv2rgb_pkg::LATENCY))
        else $error("RGB request not passed through unchanged");

    a_alpha_kept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rgb888_word[29:24] == $past(color_word[29:24], phsv2rgb_pkg::LATENCY))
        else $error("alpha altered");

    a_565_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rgb565_word == {rgb888_word[23:19], rgb888_word[15:10], rgb888_word[7:3]})
        else $error("RGB565 word disagrees with RGB888 word");

endmodule

// ===== tb/sv/tb_packed_hsv_to_rgb_convert.sv =====
`timescale 1ns / 100ps

module tb_packed_hsv_to_rgb_convert;

    localparam int unsigned RANDOM_REQUESTS = 1650;
    localparam int unsigned DIRECTED_ROWS   = 22;

    typedef struct packed {
        logic [31:0] word;
        logic [29:0] rgb888;
        logic [15:0] rgb565;
    } colour_result_t;

    typedef struct packed {
        logic [31:0] word;
        logic        fixed;
        logic [29:0] rgb888;
        logic [15:0] rgb565;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] color_word;
    logic        done;
    logic [29:0] rgb888_word;
    logic [15:0] rgb565_word;

    // Hand-typed expectation travelling alongside a directed request.
    logic        req_fixed;
    logic [29:0] req_rgb888;
    logic [15:0] req_rgb565;

    colour_result_t expected_colours[$];
    int unsigned    mismatch_count;
    stim_row_t      directed_rows [0:DIRECTED_ROWS-1];

    packed_hsv_to_rgb_convert dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .color_word (color_word),
        .done       (done),
        .rgb888_word(rgb888_word),
        .rgb565_word(rgb565_word)
    );

    always #2 clk = ~clk;

    function automatic colour_result_t convert_to_rgb(input logic [31:0] w);
        colour_result_t        res;
        logic [31:0]           rgb;
        int unsigned           hue;
        int unsigned           rem;
        int unsigned           sat;
        int unsigned           v;
        int unsigned           p;
        int unsigned           qdn;
        int unsigned           qup;
        logic [7:0]            r;
        logic [7:0]            g;
        logic [7:0]            b;
        phsv2rgb_pkg::region_t region;
        res.word = w;
        if (w[phsv2rgb_pkg::HSV_FLAG_BIT])
        begin
            sat = w[11:6];
            hue = w[23:12];
            hue = hue % phsv2rgb_pkg::HUE_RANGE;
            if (w[phsv2rgb_pkg::HUE_NEG_BIT] && hue != 0)
            begin
                hue = phsv2rgb_pkg::HUE_RANGE - hue;
            end
            region = phsv2rgb_pkg::region_t'(hue / phsv2rgb_pkg::HUE_SECT);
            rem    = hue - (hue / phsv2rgb_pkg::HUE_SECT) * phsv2rgb_pkg::HUE_SECT;
            v      = w[5:0];
            v      = (v * 255) / phsv2rgb_pkg::LEVEL_MAX;
            p      = (v * (phsv2rgb_pkg::LEVEL_MAX - sat)) / phsv2rgb_pkg::LEVEL_MAX;
            // The falling level serves odd regions, the rising level even ones.
            qdn    = (v * (phsv2rgb_pkg::QDIV - sat * rem)) / phsv2rgb_pkg::QDIV;
            qup    = (v * (phsv2rgb_pkg::QDIV - sat * (phsv2rgb_pkg::REM_MAX - rem)))
                     / phsv2rgb_pkg::QDIV;
            case (region)
                phsv2rgb_pkg::REGION_0:
                begin
                    r = 8'(v);   g = 8'(qup); b = 8'(p);
                end
                phsv2rgb_pkg::REGION_1:
                begin
                    r = 8'(qdn); g = 8'(v);   b = 8'(p);
                end
                phsv2rgb_pkg::REGION_2:
                begin
                    r = 8'(p);   g = 8'(v);   b = 8'(qup);
                end
                phsv2rgb_pkg::REGION_3:
                begin
                    r = 8'(p);   g = 8'(qdn); b = 8'(v);
                end
                phsv2rgb_pkg::REGION_4:
                begin
                    r = 8'(qup); g = 8'(p);   b = 8'(v);
                end
                default:
                begin
                    r = 8'(v);   g = 8'(p);   b = 8'(qdn);
                end
            endcase
            rgb = {2'b00, w[29:24], r, g, b};
        end
        else
        begin
            rgb = w;
        end
        res.rgb888 = rgb[29:0];
        res.rgb565 = {rgb[23:19], rgb[15:10], rgb[7:3]};
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Holds start high until the request is taken, then returns at that edge.
    task automatic send_request(input logic [31:0] w, input logic fixed,
                                input logic [29:0] exp888, input logic [15:0] exp565);
        start      <= 1'b1;
        color_word <= w;
        req_fixed  <= fixed;
        req_rgb888 <= exp888;
        req_rgb565 <= exp565;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic idle_for(input int unsigned cycles);
        if (cycles != 0)
        begin
            start      <= 1'b0;
            color_word <= $urandom;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [31:0] random_colour_word();
        int unsigned kind;
        logic [11:0] mag;
        kind = $urandom_range(0, 3);
        if (kind < 2)
        begin
            // Hue magnitude mostly within one turn, sometimes any 12-bit pattern.
            mag = ($urandom_range(0, 2) == 0) ?
                  12'($urandom_range(0, 4095)) :
                  12'($urandom_range(0, phsv2rgb_pkg::HUE_RANGE - 1));
            return {1'b1, 1'($urandom_range(0, 1)), 6'($urandom), mag,
                    6'($urandom), 6'($urandom)};
        end
        else if (kind == 2)
        begin
            return {1'b0, 31'($urandom)};
        end
        return $urandom;
    endfunction

    // Record the expectation for every request the block takes.
    always @(posedge clk)
    begin
        colour_result_t res;
        if (rst_n && start && !busy)
        begin
            res = convert_to_rgb(color_word);
            if (req_fixed)
            begin
                res.rgb888 = req_rgb888;
                res.rgb565 = req_rgb565;
            end
            expected_colours.push_back(res);
        end
    end

    always @(posedge clk)
    begin
        colour_result_t want;
        if (rst_n && done)
        begin
            if (expected_colours.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result rgb888=%h rgb565=%h",
                                          rgb888_word, rgb565_word));
            end
            else
            begin
                want = expected_colours.pop_front();
                if (rgb888_word !== want.rgb888)
                begin
                    report_mismatch($sformatf("word %h: rgb888 %h, expected %h",
                                              want.word, rgb888_word, want.rgb888));
                end
                if (rgb565_word !== want.rgb565)
                begin
                    report_mismatch($sformatf("word %h: rgb565 %h, expected %h",
                                              want.word, rgb565_word, want.rgb565));
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL packed_hsv_to_rgb_convert");
        $finish;
    end

    initial
    begin
        int unsigned burst_left;
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        color_word     = 32'd0;
        req_fixed      = 1'b0;
        req_rgb888     = 30'd0;
        req_rgb565     = 16'd0;
        mismatch_count = 0;
        burst_left     = 0;

        directed_rows = '{
            '{32'h0000_0000, 1'b1, 30'h0000_0000, 16'h0000},
            '{32'h7fff_ffff, 1'b1, 30'h3fff_ffff, 16'hffff},
            '{32'h4012_3456, 1'b1, 30'h0012_3456, 16'h11aa},
            '{32'h3f00_0000, 1'b1, 30'h3f00_0000, 16'h0000},
            '{32'h8000_0000, 1'b1, 30'h0000_0000, 16'h0000},
            '{32'h8000_003f, 1'b1, 30'h00ff_ffff, 16'hffff},
            '{32'h8000_0fff, 1'b1, 30'h00ff_0000, 16'hf800},
            '{32'h8003_cfff, 1'b1, 30'h00ff_ff00, 16'hffe0},
            '{32'h8007_8fff, 1'b1, 30'h0000_ff00, 16'h07e0},
            '{32'h800b_4fff, 1'b1, 30'h0000_ffff, 16'h07ff},
            '{32'h800f_0fff, 1'b1, 30'h0000_00ff, 16'h001f},
            '{32'h8012_cfff, 1'b1, 30'h00ff_00ff, 16'hf81f},
            '{32'hc000_0fff, 1'b1, 30'h00ff_0000, 16'hf800},
            '{32'hc016_8fff, 1'b1, 30'h00ff_0000, 16'hf800},
            '{32'hc007_8fff, 1'b1, 30'h0000_00ff, 16'h001f},
            '{32'hbf00_0fff, 1'b1, 30'h3fff_0000, 16'hf800},
            '{32'hbfff_ffff, 1'b0, 30'h0,        16'h0},
            '{32'hffff_ffff, 1'b0, 30'h0,        16'h0},
            '{32'h8016_7fff, 1'b0, 30'h0,        16'h0},
            '{32'h8003_bfff, 1'b0, 30'h0,        16'h0},
            '{32'h8005_a820, 1'b0, 30'h0,        16'h0},
            '{32'hc016_9fc1, 1'b0, 30'h0,        16'h0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].word, directed_rows[i].fixed,
                         directed_rows[i].rgb888, directed_rows[i].rgb565);
            idle_for(pick_gap());
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            send_request(random_colour_word(), 1'b0, 30'd0, 16'd0);
            // Now and then a back-to-back stretch at the full request rate.
            if (burst_left == 0 && $urandom_range(0, 99) < 3)
            begin
                burst_left = $urandom_range(20, 60);
            end
            if (burst_left != 0)
            begin
                burst_left--;
            end
            else
            begin
                idle_for(pick_gap());
            end
        end
        start <= 1'b0;

        for (int n = 0; n < 20 * phsv2rgb_pkg::LATENCY && expected_colours.size() != 0; n++)
        begin
            @(posedge clk);
        end
        repeat (phsv2rgb_pkg::LATENCY + 4) @(posedge clk);
        if (expected_colours.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_colours.size()));
        end

        if (mismatch_count == 0)
        begin
            $display("PASS packed_hsv_to_rgb_convert");
        end
        else
        begin
            $display("FAIL packed_hsv_to_rgb_convert");
        end
        $finish;
    end

endmodule
